@@ src/page_table_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// page_table_mapper_defines.svh
// Assertion macros shared by the page table mapper RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAPPER_DEFINES_SVH
`define PAGE_TABLE_MAPPER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and off during reset.
`define PTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and off during reset.
`define PTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptm_pkg
// Types and constants shared by the page table mapper modules.
// ----------------------------------------------------------------------------
package ptm_pkg;

    localparam int PN_W      = 36;
    localparam int WORD_W    = 64;
    localparam int ENTRY_W   = 9;
    localparam int PAGE_SH   = 12;
    localparam logic [1:0] DESC_TABLE = 2'b11;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_PAGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        AS_WALK  = 2'd0,
        AS_CLEAR = 2'd1,
        AS_LEAF  = 2'd2,
        AS_READ  = 2'd3
    } t_asel;

    typedef enum logic [1:0] {
        WS_ZERO = 2'd0,
        WS_LINK = 2'd1,
        WS_LEAF = 2'd2
    } t_wsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK_RD,
        S_WALK_CHK,
        S_CLEAR,
        S_LINK,
        S_LEAF,
        S_READ_RD,
        S_READ_WAIT,
        S_DONE
    } t_ctrl_state;

    typedef struct packed {
        logic    load;
        logic    cur_from_root;
        logic    cur_from_entry;
        logic    cur_from_new;
        logic    lvl_inc;
        logic    grab;
        logic    clr_step;
        logic    mem_rd;
        logic    mem_wr;
        t_asel   asel;
        t_wsel   wsel;
        logic    word_alloc;
        logic    word_leaf;
        logic    word_read;
        logic    set_status;
        t_status status_code;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    root_ok;
        logic    entry_ok;
        logic    entry_valid;
        logic    full;
        logic    clr_last;
        logic    last_lvl;
    } t_dp_sts;

endpackage

@@ src/ptm_ram.sv @@
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-clock RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ptm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer for map, allocate and read operations of the page table mapper.
// ----------------------------------------------------------------------------
module ptm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ptm_pkg::t_dp_sts  i_sts,
    output ptm_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    import ptm_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE, S_DONE: begin
                n_state = i_start ? S_DECODE : S_IDLE;
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_MAP:   n_state = i_sts.root_ok ? S_WALK_RD : S_DONE;
                    OP_ALLOC: n_state = i_sts.full ? S_DONE : S_CLEAR;
                    OP_READ:  n_state = i_sts.root_ok ? S_READ_RD : S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_WALK_RD: n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if (i_sts.entry_valid) begin
                    if (!i_sts.entry_ok) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = i_sts.last_lvl ? S_LEAF : S_WALK_RD;
                    end
                end else begin
                    n_state = i_sts.full ? S_DONE : S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = (i_sts.op == OP_MAP) ? S_LINK : S_DONE;
                end
            end
            S_LINK:      n_state = i_sts.last_lvl ? S_LEAF : S_WALK_RD;
            S_LEAF:      n_state = S_DONE;
            S_READ_RD:   n_state = S_READ_WAIT;
            S_READ_WAIT: n_state = S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load           = 1'b0;
        o_cmd.cur_from_root  = 1'b0;
        o_cmd.cur_from_entry = 1'b0;
        o_cmd.cur_from_new   = 1'b0;
        o_cmd.lvl_inc        = 1'b0;
        o_cmd.grab           = 1'b0;
        o_cmd.clr_step       = 1'b0;
        o_cmd.mem_rd         = 1'b0;
        o_cmd.mem_wr         = 1'b0;
        o_cmd.asel           = AS_WALK;
        o_cmd.wsel           = WS_ZERO;
        o_cmd.word_alloc     = 1'b0;
        o_cmd.word_leaf      = 1'b0;
        o_cmd.word_read      = 1'b0;
        o_cmd.set_status     = 1'b0;
        o_cmd.status_code    = ST_OK;
        o_busy               = 1'b1;
        o_done               = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_DONE: begin
                o_busy     = 1'b0;
                o_done     = 1'b1;
                o_cmd.load = i_start;
            end
            S_DECODE: begin
                unique case (i_sts.op) inside
                    OP_MAP, OP_READ: begin
                        if (i_sts.root_ok) begin
                            o_cmd.cur_from_root = 1'b1;
                        end else begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_BAD_PAGE;
                        end
                    end
                    OP_ALLOC: begin
                        if (i_sts.full) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_NO_SPACE;
                        end else begin
                            o_cmd.grab = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_WALK_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = AS_WALK;
            end
            S_WALK_CHK: begin
                if (i_sts.entry_valid) begin
                    if (i_sts.entry_ok) begin
                        o_cmd.cur_from_entry = 1'b1;
                        o_cmd.lvl_inc        = 1'b1;
                    end else begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_BAD_PAGE;
                    end
                end else if (i_sts.full) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_NO_SPACE;
                end else begin
                    o_cmd.grab = 1'b1;
                end
            end
            S_CLEAR: begin
                o_cmd.mem_wr     = 1'b1;
                o_cmd.asel       = AS_CLEAR;
                o_cmd.wsel       = WS_ZERO;
                o_cmd.clr_step   = 1'b1;
                o_cmd.word_alloc = i_sts.clr_last && (i_sts.op == OP_ALLOC);
            end
            S_LINK: begin
                o_cmd.mem_wr       = 1'b1;
                o_cmd.asel         = AS_WALK;
                o_cmd.wsel         = WS_LINK;
                o_cmd.cur_from_new = 1'b1;
                o_cmd.lvl_inc      = 1'b1;
            end
            S_LEAF: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.asel      = AS_LEAF;
                o_cmd.wsel      = WS_LEAF;
                o_cmd.word_leaf = 1'b1;
            end
            S_READ_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = AS_READ;
            end
            S_READ_WAIT: begin
                o_cmd.word_read = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ src/ptm_datapath.sv @@
// ----------------------------------------------------------------------------
// ptm_datapath
// Operand registers, page allocator, slot checks and table store access.
// ----------------------------------------------------------------------------
module ptm_datapath #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ptm_pkg::t_dp_cmd                 i_cmd,
    output ptm_pkg::t_dp_sts                 o_sts,
    input  logic [ptm_pkg::PN_W-1:0]         i_base,
    input  logic [1:0]                       i_opcode,
    input  logic [ptm_pkg::PN_W-1:0]         i_root_page,
    input  logic [ptm_pkg::PN_W-1:0]         i_virt_page,
    input  logic [ptm_pkg::PN_W-1:0]         i_phys_page,
    input  logic [2:0]                       i_attr_index,
    input  logic                             i_user_access,
    input  logic [ptm_pkg::ENTRY_W-1:0]      i_entry_index,
    output logic [1:0]                       o_status,
    output logic [ptm_pkg::WORD_W-1:0]       o_result_word,
    output logic [$clog2(TABLE_PAGES+1)-1:0] o_pages_used
);

    import ptm_pkg::*;

    localparam int SW    = $clog2(TABLE_PAGES);
    localparam int CW    = $clog2(TABLE_PAGES + 1);
    localparam int AW    = SW + ENTRY_W;
    localparam int DEPTH = TABLE_PAGES * (2 ** ENTRY_W);

    t_opcode             r_op;
    logic [PN_W-1:0]     r_root;
    logic [PN_W-1:0]     r_va;
    logic [PN_W-1:0]     r_pa;
    logic [2:0]          r_attr;
    logic                r_user;
    logic [ENTRY_W-1:0]  r_ei;
    logic [SW-1:0]       r_cur;
    logic [SW-1:0]       r_new;
    logic [1:0]          r_lvl;
    logic [ENTRY_W-1:0]  r_clr;
    logic [CW-1:0]       r_next_free;
    t_status             r_status;
    logic [WORD_W-1:0]   r_word;

    logic [WORD_W-1:0]   rdata;
    logic [PN_W-1:0]     k_root;
    logic [PN_W-1:0]     k_entry;
    logic [PN_W-1:0]     used_ext;
    logic [PN_W-1:0]     new_pn;
    logic [ENTRY_W-1:0]  walk_idx;
    logic [WORD_W-1:0]   new_addr;
    logic [WORD_W-1:0]   leaf;
    logic [AW-1:0]       mem_addr;
    logic [WORD_W-1:0]   mem_wdata;

    assign used_ext = {{(PN_W-CW){1'b0}}, r_next_free};
    assign k_root   = r_root - i_base;
    assign k_entry  = rdata[PN_W+PAGE_SH-1:PAGE_SH] - i_base;
    assign new_pn   = i_base + {{(PN_W-SW){1'b0}}, r_new};
    assign new_addr = {{(WORD_W-PN_W-PAGE_SH){1'b0}}, new_pn, {PAGE_SH{1'b0}}};
    assign leaf     = {9'b0, 1'b1, 6'b0, r_pa, 1'b0, 1'b1, 2'b11, 1'b0, r_user,
                       1'b0, r_attr, 2'b11};

    always_comb begin
        case (r_lvl)
            2'd0:    walk_idx = r_va[35:27];
            2'd1:    walk_idx = r_va[26:18];
            default: walk_idx = r_va[17:9];
        endcase
    end

    always_comb begin
        unique case (i_cmd.asel)
            AS_WALK:  mem_addr = {r_cur, walk_idx};
            AS_CLEAR: mem_addr = {r_new, r_clr};
            AS_LEAF:  mem_addr = {r_cur, r_va[ENTRY_W-1:0]};
            default:  mem_addr = {r_cur, r_ei};
        endcase
    end

    always_comb begin
        unique case (i_cmd.wsel)
            WS_LINK: mem_wdata = new_addr | {{(WORD_W-2){1'b0}}, DESC_TABLE};
            WS_LEAF: mem_wdata = leaf;
            default: mem_wdata = '0;
        endcase
    end

    ptm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (mem_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
            r_lvl       <= '0;
        end else begin
            if (i_cmd.load) begin
                r_lvl <= '0;
            end else if (i_cmd.lvl_inc) begin
                r_lvl <= r_lvl + 2'd1;
            end
            if (i_cmd.grab) begin
                r_next_free <= r_next_free + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_opcode'(i_opcode);
            r_root   <= i_root_page;
            r_va     <= i_virt_page;
            r_pa     <= i_phys_page;
            r_attr   <= i_attr_index;
            r_user   <= i_user_access;
            r_ei     <= i_entry_index;
            r_status <= ST_OK;
            r_word   <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_code;
            end
            if (i_cmd.word_alloc) begin
                r_word <= new_addr;
            end else if (i_cmd.word_leaf) begin
                r_word <= leaf;
            end else if (i_cmd.word_read) begin
                r_word <= rdata;
            end
        end
        if (i_cmd.cur_from_root) begin
            r_cur <= k_root[SW-1:0];
        end else if (i_cmd.cur_from_entry) begin
            r_cur <= k_entry[SW-1:0];
        end else if (i_cmd.cur_from_new) begin
            r_cur <= r_new;
        end
        if (i_cmd.grab) begin
            r_new <= r_next_free[SW-1:0];
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + ENTRY_W'(1);
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.root_ok     = (k_root < used_ext);
    assign o_sts.entry_ok    = (k_entry < used_ext);
    assign o_sts.entry_valid = rdata[0];
    assign o_sts.full        = (r_next_free == CW'(TABLE_PAGES));
    assign o_sts.clr_last    = &r_clr;
    assign o_sts.last_lvl    = (r_lvl == 2'd2);

    assign o_status      = r_status;
    assign o_result_word = r_word;
    assign o_pages_used  = r_next_free;

endmodule

@@ src/page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// page_table_mapper
// Builds four-level 4 KB-granule translation tables in an internal store.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// for one cycle with o_done high, and the receiver cannot stall it. A read
// reads the selected entry of the root table and returns it. A map walks
// the existing tables, clears and links each table page it has to create,
// and then writes the leaf entry. An allocate clears its page without
// linking it. The table store is a RAM with a registered read that shares
// one address between read and write, and the walk spends a read state and
// a check state on each of the three levels. A new command
// may be started in the cycle that shows the previous result.
module page_table_mapper #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_opcode,
    input  logic [ptm_pkg::PN_W-1:0]         i_root_page,
    input  logic [ptm_pkg::PN_W-1:0]         i_virt_page,
    input  logic [ptm_pkg::PN_W-1:0]         i_phys_page,
    input  logic [2:0]                       i_attr_index,
    input  logic                             i_user_access,
    input  logic [ptm_pkg::ENTRY_W-1:0]      i_entry_index,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [ptm_pkg::WORD_W-1:0]       o_result_word,
    output logic [$clog2(TABLE_PAGES+1)-1:0] o_pages_used
);

    import ptm_pkg::*;

    `include "page_table_mapper_defines.svh"

    logic [PN_W-1:0] r_base;
    logic            cfg_wr;
    t_dp_cmd         cmd;
    t_dp_sts         sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {{(64-PN_W){1'b0}}, r_base} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (cfg_wr) begin
            r_base <= pwdata[PN_W-1:0];
        end
    end

    ptm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ptm_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_base        (r_base),
        .i_opcode      (i_opcode),
        .i_root_page   (i_root_page),
        .i_virt_page   (i_virt_page),
        .i_phys_page   (i_phys_page),
        .i_attr_index  (i_attr_index),
        .i_user_access (i_user_access),
        .i_entry_index (i_entry_index),
        .o_status      (o_status),
        .o_result_word (o_result_word),
        .o_pages_used  (o_pages_used)
    );

    `PTM_ASSERT_NOW(a_done_not_busy, o_done, !busy, "result word shown while busy")
    `PTM_ASSERT_NOW(a_error_zero_word, o_done && (o_status != ST_OK),
        o_result_word == '0, "failed command returned a nonzero word")
    `PTM_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not start")

endmodule
